// ===== hw/rtl/rhh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhh_pkg
// Types, constants and hash mix helpers for the robin-hood hash table.
// ----------------------------------------------------------------------------
package rhh_pkg;

    localparam int unsigned CAPACITY = 1024;
    localparam int unsigned IDX_W    = $clog2(CAPACITY);
    localparam int unsigned CNT_W    = IDX_W + 1;
    localparam int unsigned DIST_W   = IDX_W;

    localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned MIX_SHIFT = 33;

    // most entries the table may hold: a new key needs (cnt+1)*10 <= CAPACITY*9
    localparam int unsigned LOAD_MAX = (CAPACITY * 9) / 10;

    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_GET    = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_REMOVED   = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [63:0] key;
        logic signed [63:0] value;
    } t_req;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [63:0] value_out;
        logic [10:0]        entry_count;
    } t_rsp;

    // datapath commands
    typedef enum logic [3:0] {
        DC_NOP,
        DC_LOAD,     // capture request
        DC_MIX1,     // x ^= x>>33
        DC_MUL_LO,   // acc = x.lo * c.lo
        DC_MUL_HI1,  // acc.hi += x.hi * c.lo
        DC_MUL_HI2,  // x = acc + (x.lo * c.hi) << 32
        DC_MIX5,
        DC_FADV,     // advance probe
        DC_UPDVAL,   // write value at probe index
        DC_INS,      // write carried entry, swap to carry old
        DC_SHIFT,    // copy next slot back into current
        DC_CLEAR,    // empty the current slot
        DC_RESTART,  // return probe to home slot
        DC_CNT_INC,
        DC_CNT_DEC,
        DC_SWEEP     // empty the current slot and step on
    } t_dcmd;

    typedef struct packed {
        t_dcmd cmd;
        logic  read_next;  // read at index+1 instead of index
        logic  mul_c2;     // multiply by the second mix constant
    } t_ctl;

    typedef struct packed {
        logic empty;      // slot read is empty
        logic match;      // hash and key equal
        logic shorter;    // slot distance < probe distance
        logic nxt_stop;   // next slot ends a shift chain
        logic full;       // load limit reached
        logic wrapped;    // probe passed all slots
        logic last;       // probe index at the last slot
    } t_sts;

endpackage : rhh_pkg
`default_nettype wire

// ===== hw/rtl/rhh_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhh_datapath
// Hash mix, probe registers and slot memories of the hash table.
// ----------------------------------------------------------------------------
module rhh_datapath
    import rhh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_ctl i_ctl,
    output t_sts      o_sts,
    output logic [63:0] o_found_val,
    output logic [CNT_W-1:0] o_count
);

    // slot memories: hash and distance stores are zeroed by a sweep after reset
    logic [31:0]       m_hash [CAPACITY];
    logic [DIST_W-1:0] m_dist [CAPACITY];
    logic [63:0]       m_key  [CAPACITY];
    logic [63:0]       m_val  [CAPACITY];

    logic [63:0]       r_key, r_val, r_x, r_acc;
    logic [31:0]       r_h;
    logic [IDX_W-1:0]  r_idx;
    logic [DIST_W:0]   r_dist;
    logic [CNT_W-1:0]  r_cnt;

    // registered read of the current or next slot
    logic [31:0]       r_rd_hash;
    logic [DIST_W-1:0] r_rd_dist;
    logic [63:0]       r_rd_key, r_rd_val;

    logic [IDX_W-1:0]  w_rd_addr, w_nxt;
    logic [63:0]       w_x1;
    logic [31:0]       w_hfin;
    logic              w_rd_empty;
    logic [63:0]       w_mc;
    logic [31:0]       w_ma, w_mb;
    logic [63:0]       w_prod;

    assign w_nxt     = r_idx + IDX_W'(1);
    assign w_rd_addr = i_ctl.read_next ? w_nxt : r_idx;
    assign w_x1      = r_x ^ (r_x >> MIX_SHIFT);
    assign w_hfin    = (w_x1[31:0] == 32'd0) ? 32'd1 : w_x1[31:0];
    assign w_rd_empty = (r_rd_hash == 32'd0);

    // one 32x32 multiplier, operand halves picked by the step
    assign w_mc = i_ctl.mul_c2 ? MIX_C2 : MIX_C1;
    always_comb begin
        case (i_ctl.cmd)
            DC_MUL_HI1: begin
                w_ma = r_x[63:32];
                w_mb = w_mc[31:0];
            end
            DC_MUL_HI2: begin
                w_ma = r_x[31:0];
                w_mb = w_mc[63:32];
            end
            default: begin
                w_ma = r_x[31:0];
                w_mb = w_mc[31:0];
            end
        endcase
    end
    assign w_prod = w_ma * w_mb;

    // memory read port
    always_ff @(posedge i_clk) begin
        r_rd_hash <= m_hash[w_rd_addr];
        r_rd_dist <= m_dist[w_rd_addr];
        r_rd_key  <= m_key[w_rd_addr];
        r_rd_val  <= m_val[w_rd_addr];
    end

    // memory write port
    always_ff @(posedge i_clk) begin
        case (i_ctl.cmd)
            DC_UPDVAL: m_val[r_idx] <= r_val;
            DC_INS: begin
                m_hash[r_idx] <= r_h;
                m_dist[r_idx] <= r_dist[DIST_W-1:0];
                m_key[r_idx]  <= r_key;
                m_val[r_idx]  <= r_val;
            end
            DC_SHIFT: begin
                m_hash[r_idx] <= r_rd_hash;
                m_dist[r_idx] <= r_rd_dist - DIST_W'(1);
                m_key[r_idx]  <= r_rd_key;
                m_val[r_idx]  <= r_rd_val;
            end
            DC_CLEAR, DC_SWEEP: begin
                m_hash[r_idx] <= 32'd0;
                m_dist[r_idx] <= '0;
            end
            default: ;
        endcase
    end

    // probe, mix and carried-entry registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            case (i_ctl.cmd)
                DC_LOAD: begin
                    r_key <= i_req.key;
                    r_val <= i_req.value;
                    r_x   <= i_req.key;
                end
                DC_MIX1:    r_x <= w_x1;
                DC_MUL_LO:  r_acc <= w_prod;
                DC_MUL_HI1: r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
                DC_MUL_HI2: r_x <= {r_acc[63:32] + w_prod[31:0], r_acc[31:0]};
                DC_MIX5: begin
                    r_h    <= w_hfin;
                    r_idx  <= w_hfin[IDX_W-1:0];
                    r_dist <= '0;
                end
                DC_RESTART: begin
                    r_idx  <= r_h[IDX_W-1:0];
                    r_dist <= '0;
                end
                DC_FADV: begin
                    r_idx  <= w_nxt;
                    r_dist <= r_dist + 1'b1;
                end
                DC_INS: begin
                    // carry displaced occupant forward
                    r_h    <= r_rd_hash;
                    r_key  <= r_rd_key;
                    r_val  <= r_rd_val;
                    r_dist <= {1'b0, r_rd_dist} + 1'b1;
                    r_idx  <= w_nxt;
                end
                DC_SHIFT: r_idx <= w_nxt;
                DC_SWEEP: r_idx <= w_nxt;
                default: ;
            endcase
        end
    end

    // occupied count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.cmd == DC_CNT_INC) begin
            r_cnt <= r_cnt + 1'b1;
        end else if (i_ctl.cmd == DC_CNT_DEC && r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // status toward the controller
    assign o_sts.empty    = w_rd_empty;
    assign o_sts.match    = (r_rd_hash == r_h) && (r_rd_key == r_key);
    assign o_sts.shorter  = !w_rd_empty && ({1'b0, r_rd_dist} < r_dist);
    assign o_sts.nxt_stop = w_rd_empty || r_rd_dist == '0;
    assign o_sts.full     = r_cnt >= CNT_W'(LOAD_MAX);
    assign o_sts.wrapped  = r_dist[DIST_W];
    assign o_sts.last     = (r_idx == {IDX_W{1'b1}});
    assign o_found_val    = r_rd_val;
    assign o_count        = r_cnt;

endmodule : rhh_datapath
`default_nettype wire

// ===== hw/rtl/rhh_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhh_ctrl
// Sequencer for find, update, insert with swap and backward-shift removal.
// ----------------------------------------------------------------------------
module rhh_ctrl
    import rhh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic [1:0] i_action,
    input  wire t_sts i_sts,
    input  wire logic [63:0] i_found_val,
    input  wire logic [CNT_W-1:0] i_count,
    output t_ctl      o_ctl,
    output logic      busy,
    output logic      done,
    output t_rsp      o_rsp
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_M1, S_M2A, S_M2B, S_M2C, S_M3, S_M4A, S_M4B, S_M4C, S_M5,
        S_FRD, S_FCHK, S_INS_RD, S_INS_CHK, S_RM_RD, S_RM_CHK, S_RM_FIN, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_act;
    t_status    r_st, n_st;
    logic [63:0] r_vout, n_vout;
    logic       r_cntop, n_cntop;
    logic       r_done;

    // next state and datapath command
    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        n_vout  = r_vout;
        n_cntop = 1'b0;
        o_ctl.cmd = DC_NOP;
        o_ctl.read_next = 1'b0;
        o_ctl.mul_c2 = 1'b0;
        case (r_state)
            S_INIT: begin
                // empty every slot once after reset
                o_ctl.cmd = DC_SWEEP;
                if (i_sts.last) n_state = S_IDLE;
            end
            S_IDLE: if (start) begin
                o_ctl.cmd = DC_LOAD;
                n_vout  = '0;
                n_state = S_M1;
            end
            S_M1:  begin o_ctl.cmd = DC_MIX1;    n_state = S_M2A; end
            S_M2A: begin o_ctl.cmd = DC_MUL_LO;  n_state = S_M2B; end
            S_M2B: begin o_ctl.cmd = DC_MUL_HI1; n_state = S_M2C; end
            S_M2C: begin o_ctl.cmd = DC_MUL_HI2; n_state = S_M3; end
            S_M3:  begin o_ctl.cmd = DC_MIX1;    n_state = S_M4A; end
            S_M4A: begin
                o_ctl.cmd = DC_MUL_LO;
                o_ctl.mul_c2 = 1'b1;
                n_state = S_M4B;
            end
            S_M4B: begin
                o_ctl.cmd = DC_MUL_HI1;
                o_ctl.mul_c2 = 1'b1;
                n_state = S_M4C;
            end
            S_M4C: begin
                o_ctl.cmd = DC_MUL_HI2;
                o_ctl.mul_c2 = 1'b1;
                n_state = S_M5;
            end
            S_M5: begin
                o_ctl.cmd = DC_MIX5;
                n_state = (r_act == ACT_NONE) ? S_DONE : S_FRD;
                n_st    = ST_NOT_FOUND;
            end
            S_FRD: n_state = S_FCHK;
            S_FCHK: begin
                if (i_sts.empty || i_sts.shorter || i_sts.wrapped) begin
                    if (r_act == ACT_PUT && !i_sts.full) begin
                        o_ctl.cmd = DC_RESTART;
                        n_state   = S_INS_RD;
                    end else begin
                        n_st    = (r_act == ACT_PUT) ? ST_FULL : ST_NOT_FOUND;
                        n_state = S_DONE;
                    end
                end else if (i_sts.match) begin
                    case (r_act)
                        ACT_PUT: begin
                            o_ctl.cmd = DC_UPDVAL;
                            n_st = ST_UPDATED;
                            n_state = S_DONE;
                        end
                        ACT_GET: begin
                            n_st = ST_FOUND;
                            n_vout = i_found_val;
                            n_state = S_DONE;
                        end
                        default: begin
                            n_st = ST_REMOVED;
                            o_ctl.read_next = 1'b1;
                            n_state = S_RM_CHK;
                        end
                    endcase
                end else begin
                    o_ctl.cmd = DC_FADV;
                    n_state = S_FRD;
                end
            end
            S_INS_RD: n_state = S_INS_CHK;
            S_INS_CHK: begin
                if (i_sts.empty) begin
                    o_ctl.cmd = DC_INS;
                    n_st = ST_INSERTED;
                    n_cntop = 1'b1;
                    n_state = S_DONE;
                end else if (i_sts.shorter) begin
                    o_ctl.cmd = DC_INS;
                    n_state = S_INS_RD;
                end else begin
                    o_ctl.cmd = DC_FADV;
                    n_state = S_INS_RD;
                end
            end
            S_RM_RD: begin
                o_ctl.read_next = 1'b1;
                n_state = S_RM_CHK;
            end
            S_RM_CHK: begin
                // keep the read on the next slot
                o_ctl.read_next = 1'b1;
                n_state = S_RM_FIN;
            end
            S_RM_FIN: begin
                // next slot data is registered now
                if (i_sts.nxt_stop) begin
                    o_ctl.cmd = DC_CLEAR;
                    n_cntop = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_ctl.cmd = DC_SHIFT;
                    n_state = S_RM_RD;
                end
            end
            S_DONE: begin
                if (r_cntop) begin
                    o_ctl.cmd = (r_st == ST_INSERTED) ? DC_CNT_INC : DC_CNT_DEC;
                end
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_act   <= ACT_NONE;
            r_st    <= ST_NOT_FOUND;
            r_vout  <= '0;
            r_cntop <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_vout  <= n_vout;
            if (r_state != S_DONE) r_cntop <= r_cntop | n_cntop;
            else r_cntop <= 1'b0;
            if (r_state == S_IDLE && start) r_act <= i_action;
            r_done  <= (r_state == S_DONE);
        end
    end

    assign busy = (r_state != S_IDLE);
    assign done = r_done;
    assign o_rsp.status      = r_st;
    assign o_rsp.value_out   = (r_st == ST_FOUND) ? r_vout : 64'd0;
    assign o_rsp.entry_count = i_count;

    // a result strobe always follows the end of a request
    a_done_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |=> r_done) else $error("missing result strobe");
    a_idle_no_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE) else $error("strobe while working");
    a_vout_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_FOUND |-> o_rsp.value_out == 64'd0) else $error("stray value");

endmodule : rhh_ctrl
`default_nettype wire

// ===== hw/rtl/robin_hood_hash_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Open-addressed robin-hood hash table, 1024 slots, 64-bit keys and values.
//
//  channel  | ports                        | handshake
//  request  | i_req                        | start high, busy low
//  result   | o_rsp                        | done strobe, one cycle
//
// A get, an update, a miss or a refused put runs the hash mix, then probes
// slots from home; an insert then walks again from home to the free slot,
// swapping with entries nearer their home, and a remove shifts the entries
// after it back; action 3 runs the mix only. The next item can be taken at
// the edge that ends the strobe. Each 64-bit mix multiply runs as three
// 32x32 steps; the slot memory with its registered read splits each probe
// step into a read state and a check state. After reset busy stays high
// while the hash and distance stores are swept to zero. The result cannot be stalled.
// ----------------------------------------------------------------------------
module robin_hood_hash_table
    import rhh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      done,
    output t_rsp      o_rsp
);

    t_ctl w_ctl;
    t_sts w_sts;
    logic [63:0] w_found;
    logic [CNT_W-1:0] w_cnt;
    logic w_busy;

    rhh_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(i_req), .i_ctl(w_ctl),
        .o_sts(w_sts), .o_found_val(w_found), .o_count(w_cnt)
    );

    rhh_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start && !w_busy),
        .i_action(i_req.action), .i_sts(w_sts), .i_found_val(w_found),
        .i_count(w_cnt), .o_ctl(w_ctl), .busy(w_busy), .done(done), .o_rsp(o_rsp)
    );

    assign busy = w_busy;

endmodule : robin_hood_hash_table
`default_nettype wire
